// File: hw/rtl/csvt_pkg.sv
// Shared types and constants of the CSV field tokenizer.
`default_nettype none

package csvt_pkg;

    // Character codes that the tokenizer reacts to.
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSL     = 8'h5C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    // Reset value of the separator register (semicolon).
    localparam logic [7:0] SEP_RESET = 8'h3B;

    // Result buffer sizing: at most three results per byte, five candidate slots.
    localparam int MAX_RES   = 3;
    localparam int NUM_SLOTS = 5;
    localparam int CNT_W     = 2;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SEPARATOR   = 1'b0,
        CFG_SKIP_HEADER = 1'b1
    } t_cfg_idx;

    // Kind of one result.
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2
    } t_kind;

    // Error code of one result.
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_JUNK = 2'd1,
        ERR_OPEN = 2'd2
    } t_err;

    // Parser position within a field.
    typedef enum logic [2:0] {
        MODE_REC   = 3'd0,
        MODE_FLD   = 3'd1,
        MODE_UNQ   = 3'd2,
        MODE_QUO   = 3'd3,
        MODE_QSEEN = 3'd4,
        MODE_AFTER = 3'd5
    } t_mode;

    // One result as it is buffered.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_err       err;
    } t_res;

    // One candidate result of a byte, before header filtering.
    typedef struct packed {
        logic en;
        t_res res;
    } t_slot;

endpackage

`default_nettype wire

// File: hw/rtl/csv_field_tokenizer_core.sv
// CSV field tokenizer: byte stream in, unescaped field bytes and field/record markers out.
`default_nettype none

// Each accepted byte is decoded in the cycle of its transfer and its zero to three
// results are written to a three-entry result buffer that drains one result per
// cycle on the master side while m_axis_tready is high. A byte is taken when the
// buffer is empty or its last result leaves in the same cycle, so bytes that give
// zero or one result stream at one byte per clock while the output is not stalled,
// and a byte that gives several results holds the input until its last result
// leaves, paced by the single output port. The first result of a byte appears in
// the cycle after its transfer. tlast on the output marks the last result of a
// byte; tlast on the input marks the last byte of a stream, after which the parser
// returns to its start state. Configuration writes are always ready and must be issued only while the block is idle.
module csv_field_tokenizer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input byte stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [9:8] error_code, rest zero
    output logic [1:0]       m_axis_tuser,   // [1:0] item_kind
    output logic             m_axis_tlast,   // run_last
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire csvt_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import csvt_pkg::*;

    // Configuration and parser state.
    logic [7:0]       r_sep;
    logic             r_skip;
    t_mode            r_mode, n_mode;
    logic             r_bp, n_bp;
    logic             r_cr, n_cr;
    logic             r_hdr, n_hdr;
    logic             r_fresh;

    // Result buffer.
    t_res             r_res [MAX_RES];
    t_res             n_res [MAX_RES];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx;

    // Byte decode.
    logic [7:0] w_b;
    logic       w_eos;
    logic       w_take, w_esc, w_esc_rnt, w_proc;
    logic       w_is_crlf, w_is_sep, w_is_ws, w_is_quote, w_is_bsl;
    t_mode      w_mode_t;
    logic       w_bp_t;
    t_slot      w_slot [NUM_SLOTS];
    logic       w_accept, w_pop, w_pop_last, w_cfg_wr;

    assign w_b        = s_axis_tdata;
    assign w_eos      = s_axis_tlast;
    assign w_take     = !(r_cr && (w_b == CH_LF));
    assign w_esc      = r_bp && w_take;
    assign w_esc_rnt  = w_esc && ((w_b == CH_LOWER_R) || (w_b == CH_LOWER_N)
                                  || (w_b == CH_LOWER_T));
    assign w_proc     = w_take && !w_esc_rnt;
    assign w_is_crlf  = (w_b == CH_CR) || (w_b == CH_LF);
    assign w_is_sep   = (w_b == r_sep);
    assign w_is_ws    = (w_b == CH_SP) || (w_b == CH_TAB) || (w_b == CH_VT);
    assign w_is_quote = (w_b == CH_QUOTE);
    assign w_is_bsl   = (w_b == CH_BSL);

    // Handshakes.
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign w_pop_last    = w_pop && (r_idx == CNT_W'(r_cnt - 1'b1));
    assign s_axis_tready = (r_cnt == '0) || w_pop_last;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Next parser state for the byte on the input.
    always_comb begin
        w_mode_t = r_mode;
        w_bp_t   = w_esc ? 1'b0 : r_bp;
        n_cr     = 1'b0;
        if (w_proc) begin
            unique case (r_mode)
                MODE_UNQ: begin
                    if (w_is_crlf) begin
                        w_mode_t = MODE_REC;
                        n_cr     = (w_b == CH_CR);
                    end else if (w_is_sep) begin
                        w_mode_t = MODE_FLD;
                    end else if (w_is_bsl) begin
                        w_bp_t = 1'b1;
                    end
                end
                MODE_QUO: begin
                    if (w_is_quote) begin
                        w_mode_t = MODE_QSEEN;
                    end else if (w_is_bsl) begin
                        w_bp_t = 1'b1;
                    end
                end
                MODE_QSEEN, MODE_AFTER: begin
                    if ((r_mode == MODE_QSEEN) && w_is_quote) begin
                        w_mode_t = MODE_QUO;
                    end else if (w_is_crlf) begin
                        w_mode_t = MODE_REC;
                        n_cr     = (w_b == CH_CR);
                    end else if (w_is_sep) begin
                        w_mode_t = MODE_FLD;
                    end else if (w_is_ws) begin
                        w_mode_t = MODE_AFTER;
                    end else if (w_is_quote) begin
                        w_mode_t = MODE_QUO;
                    end else begin
                        // Stray byte opens a new unquoted field.
                        w_mode_t = MODE_UNQ;
                        w_bp_t   = w_is_bsl;
                    end
                end
                default: begin
                    // Start of a field.
                    if (w_is_quote) begin
                        w_mode_t = MODE_QUO;
                    end else if (w_is_crlf) begin
                        w_mode_t = MODE_REC;
                        n_cr     = (w_b == CH_CR);
                    end else if (w_is_sep) begin
                        w_mode_t = MODE_FLD;
                    end else begin
                        w_mode_t = MODE_UNQ;
                        w_bp_t   = w_is_bsl;
                    end
                end
            endcase
        end
        // The end of a stream returns the parser to its start.
        n_mode = w_eos ? MODE_REC : w_mode_t;
        n_bp   = w_eos ? 1'b0 : w_bp_t;
        if (w_eos) begin
            n_cr = 1'b0;
        end
    end

    // Candidate results of the byte, in output order.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_slot[i] = '0;
        end
        // Escape pair or a flushed lone backslash.
        if (w_esc) begin
            w_slot[0].en       = 1'b1;
            w_slot[0].res.kind = KIND_DATA;
            if (w_b == CH_LOWER_R) begin
                w_slot[0].res.data = CH_CR;
            end else if (w_b == CH_LOWER_N) begin
                w_slot[0].res.data = CH_LF;
            end else if (w_b == CH_LOWER_T) begin
                w_slot[0].res.data = CH_TAB;
            end else begin
                w_slot[0].res.data = CH_BSL;
            end
        end
        // Byte handling in the current field mode.
        if (w_proc) begin
            unique case (r_mode)
                MODE_UNQ: begin
                    if (w_is_crlf) begin
                        w_slot[1].en       = 1'b1;
                        w_slot[1].res.kind = KIND_RECORD;
                    end else if (w_is_sep) begin
                        w_slot[1].en       = 1'b1;
                        w_slot[1].res.kind = KIND_FIELD;
                    end else if (!w_is_bsl) begin
                        w_slot[1].en       = 1'b1;
                        w_slot[1].res.data = w_b;
                    end
                end
                MODE_QUO: begin
                    if (!w_is_quote && !w_is_bsl) begin
                        w_slot[1].en       = 1'b1;
                        w_slot[1].res.data = w_b;
                    end
                end
                MODE_QSEEN, MODE_AFTER: begin
                    if ((r_mode == MODE_QSEEN) && w_is_quote) begin
                        // Doubled quote inside a quoted field.
                        w_slot[1].en       = 1'b1;
                        w_slot[1].res.data = CH_QUOTE;
                    end else if (w_is_crlf) begin
                        w_slot[1].en       = 1'b1;
                        w_slot[1].res.kind = KIND_RECORD;
                    end else if (w_is_sep) begin
                        w_slot[1].en       = 1'b1;
                        w_slot[1].res.kind = KIND_FIELD;
                    end else if (!w_is_ws) begin
                        // Stray byte: close the field with an error, then start anew.
                        w_slot[1].en       = 1'b1;
                        w_slot[1].res.kind = KIND_FIELD;
                        w_slot[1].res.err  = ERR_JUNK;
                        if (!w_is_quote && !w_is_bsl) begin
                            w_slot[2].en       = 1'b1;
                            w_slot[2].res.data = w_b;
                        end
                    end
                end
                default: begin
                    // A leading quote opens a quoted field even when it is the separator.
                    if (!w_is_quote) begin
                        if (w_is_crlf) begin
                            w_slot[1].en       = 1'b1;
                            w_slot[1].res.kind = KIND_RECORD;
                        end else if (w_is_sep) begin
                            w_slot[1].en       = 1'b1;
                            w_slot[1].res.kind = KIND_FIELD;
                        end else if (!w_is_bsl) begin
                            w_slot[1].en       = 1'b1;
                            w_slot[1].res.data = w_b;
                        end
                    end
                end
            endcase
        end
        // End of stream: flush a pending backslash and close an open record.
        if (w_eos && w_bp_t) begin
            w_slot[3].en       = 1'b1;
            w_slot[3].res.data = CH_BSL;
        end
        if (w_eos && (w_mode_t != MODE_REC)) begin
            w_slot[4].en       = 1'b1;
            w_slot[4].res.kind = KIND_RECORD;
            w_slot[4].res.err  = (w_mode_t == MODE_QUO) ? ERR_OPEN : ERR_NONE;
        end
    end

    // Header suppression and packing of the kept results into the buffer.
    always_comb begin
        logic hdr;
        hdr   = r_hdr;
        n_cnt = '0;
        for (int j = 0; j < MAX_RES; j++) begin
            n_res[j] = '0;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (w_slot[i].en) begin
                if (hdr) begin
                    if (w_slot[i].res.kind == KIND_RECORD) begin
                        hdr = 1'b0;
                    end
                end else if (n_cnt != CNT_W'(MAX_RES)) begin
                    n_res[n_cnt] = w_slot[i].res;
                    n_cnt        = n_cnt + 1'b1;
                end
            end
        end
        n_hdr = w_eos ? r_skip : hdr;
    end

    // Parser state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= SEP_RESET;
            r_skip  <= 1'b1;
            r_mode  <= MODE_REC;
            r_bp    <= 1'b0;
            r_cr    <= 1'b0;
            r_hdr   <= 1'b1;
            r_fresh <= 1'b1;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_bp    <= n_bp;
            r_cr    <= n_cr;
            r_hdr   <= n_hdr;
            r_fresh <= w_eos;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_SEPARATOR: begin
                    r_sep <= i_cfg_data;
                end
                CFG_SKIP_HEADER: begin
                    r_skip <= i_cfg_data[0];
                    if (r_fresh) begin
                        r_hdr <= i_cfg_data[0];
                    end
                end
                default: begin
                    r_sep <= r_sep;
                end
            endcase
        end
    end

    // Result buffer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (w_accept) begin
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (w_pop_last) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (w_pop) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Result buffer payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int j = 0; j < MAX_RES; j++) begin
                r_res[j] <= n_res[j];
            end
        end
    end

    // Output side.
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {6'd0, r_res[r_idx].err, r_res[r_idx].data};
    assign m_axis_tuser  = r_res[r_idx].kind;
    assign m_axis_tlast  = (r_idx == CNT_W'(r_cnt - 1'b1));

    // The read position always lies inside the filled part of the buffer.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_idx < r_cnt))
        else $error("result index outside buffer fill");

    // A new byte is taken over a non-empty buffer only as its last result leaves.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (r_cnt != '0)) |-> w_pop_last)
        else $error("byte taken while results were still pending");

    // After a non-final result of a byte another one follows at once.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("run of results broken before its last result");

    // Markers carry a zero byte, and errors appear only on markers.
    a_marker_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_DATA)) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("marker result carries a data byte");

    a_error_on_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[9:8] != ERR_NONE)) |-> (m_axis_tuser != KIND_DATA))
        else $error("error code on a data result");

endmodule

`default_nettype wire

// File: tb/sv/csv_field_tokenizer_core_tb.sv
// Self-checking testbench of the CSV field tokenizer core.
`default_nettype none

module csv_field_tokenizer_core_tb;
    import csvt_pkg::*;

    // One expected result as it leaves the master side.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_err       err;
        logic       last;
    } t_tok;

    // One row of stimulus; typed rows carry their results written out by hand.
    typedef struct packed {
        logic [7:0]     b;
        logic           eos;
        logic           typed;
        logic [1:0]     n;
        t_res [2:0]     res;
    } t_row;

    localparam t_res NIL = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_cfg_idx i_cfg_index;
    logic [7:0] i_cfg_data;

    csv_field_tokenizer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Tokenizer state as the testbench tracks it.
    logic [7:0] sep_reg;
    logic       skip_reg;
    t_mode      fmode;
    logic       bsl_pend;
    logic       cr_pend;
    logic       hdr_on;
    logic       fresh;

    // Results worked out for the byte now being tokenized.
    t_tok pr_buf [MAX_RES];
    int   pr_cnt;

    t_tok pending_tokens [$];
    logic [7:0] text_bytes [$];
    bit failed = 1'b0;
    int burst_left = 0;
    bit steady = 1'b0;
    int rx_left = 0;
    int rx_pat = 0;
    int rx_cyc = 0;

    function automatic void restart_stream();
        fmode    = MODE_REC;
        bsl_pend = 1'b0;
        cr_pend  = 1'b0;
        hdr_on   = skip_reg;
        fresh    = 1'b1;
    endfunction

    // Header records swallow every result; their record end clears the header flag.
    function automatic void tok_put(t_kind k, logic [7:0] d, t_err e);
        t_tok t;
        if (hdr_on) begin
            if (k == KIND_RECORD) hdr_on = 1'b0;
        end else if (pr_cnt < MAX_RES) begin
            t.kind = k;
            t.data = (k == KIND_DATA) ? d : 8'h00;
            t.err  = e;
            t.last = 1'b0;
            pr_buf[pr_cnt] = t;
            pr_cnt++;
        end
    endfunction

    function automatic void put_data(logic [7:0] b);
        if (b == CH_BSL) bsl_pend = 1'b1;
        else tok_put(KIND_DATA, b, ERR_NONE);
    endfunction

    // CR and LF close the record before the separator is looked at.
    function automatic bit ends_unit(logic [7:0] b);
        if (b == CH_CR || b == CH_LF) begin
            tok_put(KIND_RECORD, 8'h00, ERR_NONE);
            fmode   = MODE_REC;
            cr_pend = (b == CH_CR);
            return 1'b1;
        end
        if (b == sep_reg) begin
            tok_put(KIND_FIELD, 8'h00, ERR_NONE);
            fmode = MODE_FLD;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void start_field(logic [7:0] b);
        if (b == CH_QUOTE) begin
            fmode = MODE_QUO;
        end else if (!ends_unit(b)) begin
            fmode = MODE_UNQ;
            put_data(b);
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        // An LF right after a CR belongs to the same record end.
        if (cr_pend) begin
            cr_pend = 1'b0;
            if (b == CH_LF) return;
        end
        if (bsl_pend) begin
            bsl_pend = 1'b0;
            if (b == CH_LOWER_R) begin
                tok_put(KIND_DATA, CH_CR, ERR_NONE);
                return;
            end
            if (b == CH_LOWER_N) begin
                tok_put(KIND_DATA, CH_LF, ERR_NONE);
                return;
            end
            if (b == CH_LOWER_T) begin
                tok_put(KIND_DATA, CH_TAB, ERR_NONE);
                return;
            end
            tok_put(KIND_DATA, CH_BSL, ERR_NONE);
        end
        case (fmode)
            MODE_UNQ: begin
                if (!ends_unit(b)) put_data(b);
            end
            MODE_QUO: begin
                if (b == CH_QUOTE) fmode = MODE_QSEEN;
                else put_data(b);
            end
            MODE_QSEEN, MODE_AFTER: begin
                if (fmode == MODE_QSEEN && b == CH_QUOTE) begin
                    tok_put(KIND_DATA, CH_QUOTE, ERR_NONE);
                    fmode = MODE_QUO;
                end else begin
                    fmode = MODE_AFTER;
                    // Anything but blanks or a terminator after the closing quote is junk.
                    if (!ends_unit(b)) begin
                        if (b != CH_SP && b != CH_TAB && b != CH_VT) begin
                            tok_put(KIND_FIELD, 8'h00, ERR_JUNK);
                            fmode = MODE_FLD;
                            start_field(b);
                        end
                    end
                end
            end
            default: start_field(b);
        endcase
    endfunction

    // Works out all results of one accepted byte into pr_buf.
    function automatic void tokenize_byte(logic [7:0] b, logic eos);
        t_err e;
        pr_cnt = 0;
        fresh  = 1'b0;
        take_byte(b);
        if (eos) begin
            if (bsl_pend) begin
                bsl_pend = 1'b0;
                tok_put(KIND_DATA, CH_BSL, ERR_NONE);
            end
            e = (fmode == MODE_QUO) ? ERR_OPEN : ERR_NONE;
            if (fmode != MODE_REC) tok_put(KIND_RECORD, 8'h00, e);
            restart_stream();
        end
        if (pr_cnt > 0) pr_buf[pr_cnt - 1].last = 1'b1;
    endfunction

    function automatic t_res tok(t_kind k, logic [7:0] d, t_err e);
        t_res r;
        r.kind = k;
        r.data = d;
        r.err  = e;
        return r;
    endfunction

    function automatic t_row pred_row(logic [7:0] b, logic eos);
        t_row r;
        r       = '0;
        r.b     = b;
        r.eos   = eos;
        return r;
    endfunction

    function automatic t_row typed_row(logic [7:0] b, logic eos, logic [1:0] n,
                                       t_res r0, t_res r1, t_res r2);
        t_row r;
        r        = pred_row(b, eos);
        r.typed  = 1'b1;
        r.n      = n;
        r.res[0] = r0;
        r.res[1] = r1;
        r.res[2] = r2;
        return r;
    endfunction

    // Sends one byte in bursts with random gaps, then records its expected results.
    task automatic send_item(t_row r);
        int gap;
        t_tok t;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.b;
        s_axis_tlast  <= r.eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tokenize_byte(r.b, r.eos);
        if (r.typed) begin
            for (int k = 0; k < r.n; k++) begin
                t.kind = r.res[k].kind;
                t.data = r.res[k].data;
                t.err  = r.res[k].err;
                t.last = (k == r.n - 1);
                pending_tokens.push_back(t);
            end
        end else begin
            for (int k = 0; k < pr_cnt; k++) pending_tokens.push_back(pr_buf[k]);
        end
    endtask

    // Waits until every expected result has left and the core has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers back to back; the header flag follows only on a fresh stream.
    task automatic set_format(logic [7:0] sep, logic skip);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SEPARATOR;
        i_cfg_data  <= sep;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sep_reg = sep;
        i_cfg_index <= CFG_SKIP_HEADER;
        i_cfg_data  <= {7'd0, skip};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        skip_reg = skip;
        if (fresh) hdr_on = skip;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] escape_char();
        case ($urandom_range(0, 3))
            0: return CH_LOWER_R;
            1: return CH_LOWER_N;
            2: return CH_LOWER_T;
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    // Appends one field, quoted or plain, with escapes, doubled quotes and stray junk.
    task automatic add_field();
        int n;
        n = $urandom_range(0, 5);
        if ($urandom_range(0, 2) != 0) begin
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0: begin
                        text_bytes.push_back(CH_BSL);
                        text_bytes.push_back(escape_char());
                    end
                    1: text_bytes.push_back(8'($urandom_range(0, 255)));
                    2: text_bytes.push_back(CH_SP);
                    3: text_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
                    default: text_bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
                endcase
            end
        end else begin
            text_bytes.push_back(CH_QUOTE);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0: begin
                        text_bytes.push_back(CH_QUOTE);
                        text_bytes.push_back(CH_QUOTE);
                    end
                    1: text_bytes.push_back(sep_reg);
                    2: text_bytes.push_back(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
                    3: begin
                        text_bytes.push_back(CH_BSL);
                        text_bytes.push_back(escape_char());
                    end
                    4: text_bytes.push_back(8'($urandom_range(0, 255)));
                    default: text_bytes.push_back(8'(8'h41 + $urandom_range(0, 25)));
                endcase
            end
            text_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(0, 2))
                    0: text_bytes.push_back(CH_SP);
                    1: text_bytes.push_back(CH_TAB);
                    default: text_bytes.push_back(CH_VT);
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                text_bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
        end
    endtask

    // Builds one stream: mostly records of fields, now and then plain noise.
    task automatic build_stream();
        int nf;
        text_bytes.delete();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(4, 16)) text_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                nf = $urandom_range(1, 4);
                for (int f = 0; f < nf; f++) begin
                    if (f != 0) text_bytes.push_back(sep_reg);
                    add_field();
                end
                case ($urandom_range(0, 2))
                    0: text_bytes.push_back(CH_LF);
                    1: text_bytes.push_back(CH_CR);
                    default: begin
                        text_bytes.push_back(CH_CR);
                        text_bytes.push_back(CH_LF);
                    end
                endcase
            end
        end
    endtask

    // Result check and receiver stall pattern.
    always @(posedge i_clk) begin : rx_side
        t_tok want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_tokens.size() == 0) begin
                $error("unexpected result: item_kind %0d out_byte %0h",
                       m_axis_tuser, m_axis_tdata[7:0]);
                failed = 1'b1;
            end else begin
                want = pending_tokens.pop_front();
                if (m_axis_tuser != want.kind) begin
                    $error("item_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    failed = 1'b1;
                end
                if (m_axis_tdata[7:0] != want.data) begin
                    $error("out_byte: expected %0h, got %0h", want.data, m_axis_tdata[7:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[9:8] != want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, m_axis_tdata[9:8]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[15:10] != 6'd0) begin
                    $error("tdata padding: expected 0, got %0h", m_axis_tdata[15:10]);
                    failed = 1'b1;
                end
                if (m_axis_tlast != want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
        if (rx_left == 0) begin
            rx_pat  = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        rx_cyc++;
        case (rx_pat)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= (rx_cyc % 3 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_row rows [$];
        int sent;
        int cut;
        bit keep_open;
        logic [7:0] sep;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SEPARATOR;
        i_cfg_data    = 8'h00;
        sep_reg       = SEP_RESET;
        skip_reg      = 1'b1;
        restart_stream();

        // Directed part at reset settings: semicolon separator, header skipped.
        rows.push_back(typed_row(8'h68, 1'b0, 2'd0, NIL, NIL, NIL));
        rows.push_back(typed_row(8'h3B, 1'b0, 2'd0, NIL, NIL, NIL));
        rows.push_back(typed_row(CH_CR, 1'b0, 2'd0, NIL, NIL, NIL));
        rows.push_back(typed_row(CH_LF, 1'b0, 2'd0, NIL, NIL, NIL));
        rows.push_back(typed_row(8'h00, 1'b0, 2'd1, tok(KIND_DATA, 8'h00, ERR_NONE), NIL, NIL));
        rows.push_back(typed_row(8'hFF, 1'b0, 2'd1, tok(KIND_DATA, 8'hFF, ERR_NONE), NIL, NIL));
        rows.push_back(typed_row(8'h3B, 1'b0, 2'd1, tok(KIND_FIELD, 8'h00, ERR_NONE), NIL, NIL));
        rows.push_back(typed_row(CH_QUOTE, 1'b0, 2'd0, NIL, NIL, NIL));
        rows.push_back(pred_row(8'h3B, 1'b0));
        rows.push_back(pred_row(CH_CR, 1'b0));
        rows.push_back(pred_row(CH_QUOTE, 1'b0));
        rows.push_back(pred_row(CH_QUOTE, 1'b0));
        rows.push_back(pred_row(CH_QUOTE, 1'b0));
        rows.push_back(pred_row(CH_VT, 1'b0));
        rows.push_back(typed_row(8'h6A, 1'b0, 2'd2, tok(KIND_FIELD, 8'h00, ERR_JUNK),
                                 tok(KIND_DATA, 8'h6A, ERR_NONE), NIL));
        rows.push_back(pred_row(CH_BSL, 1'b0));
        rows.push_back(pred_row(CH_LOWER_N, 1'b0));
        rows.push_back(pred_row(CH_BSL, 1'b0));
        rows.push_back(pred_row(8'h3B, 1'b0));
        rows.push_back(pred_row(CH_CR, 1'b0));
        rows.push_back(pred_row(CH_CR, 1'b0));
        rows.push_back(pred_row(CH_QUOTE, 1'b0));
        rows.push_back(pred_row(CH_QUOTE, 1'b0));
        rows.push_back(typed_row(CH_BSL, 1'b0, 2'd1, tok(KIND_FIELD, 8'h00, ERR_JUNK),
                                 NIL, NIL));
        rows.push_back(typed_row(8'h78, 1'b1, 2'd3, tok(KIND_DATA, CH_BSL, ERR_NONE),
                                 tok(KIND_DATA, 8'h78, ERR_NONE),
                                 tok(KIND_RECORD, 8'h00, ERR_NONE)));
        rows.push_back(typed_row(CH_LF, 1'b0, 2'd0, NIL, NIL, NIL));
        rows.push_back(pred_row(CH_QUOTE, 1'b0));
        rows.push_back(typed_row(CH_BSL, 1'b1, 2'd2, tok(KIND_DATA, CH_BSL, ERR_NONE),
                                 tok(KIND_RECORD, 8'h00, ERR_OPEN), NIL));
        rows.push_back(typed_row(CH_LF, 1'b1, 2'd0, NIL, NIL, NIL));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) send_item(rows[i]);

        // Random part: one phase per separator and header setting.
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0: sep = 8'h2C;
                1: sep = 8'h00;
                2: sep = 8'hFF;
                3: sep = CH_TAB;
                4: sep = CH_QUOTE;
                5: sep = CH_LF;
                6: sep = CH_BSL;
                default: sep = 8'($urandom_range(0, 255));
            endcase
            set_format(sep, (p == 7) ? 1'($urandom_range(0, 1)) : 1'(p % 2));
            steady = (p == 3);
            sent = 0;
            while (sent < 30) begin
                build_stream();
                cut = text_bytes.size();
                if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, cut);
                // Leaving the last stream open makes the next header write land mid-stream.
                keep_open = (sent + cut >= 30) && ($urandom_range(0, 1) == 1);
                for (int i = 0; i < cut; i++)
                    send_item(pred_row(text_bytes[i], (i == cut - 1) && !keep_open));
                sent += cut;
            end
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (failed) begin
            $display("*** FAILED ***");
        end else begin
            $display("*** PASSED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
